[src/glyph_column_packer_assert.svh]
// ----------------------------------------------------------------------------
// glyph_column_packer_assert.svh
// assertion macros shared by the packer modules; they sample on clk and
// are disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef GLYPH_COLUMN_PACKER_ASSERT_SVH
`define GLYPH_COLUMN_PACKER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GCP_ASSERT_IMP(lbl, ante, cons, msg)
`define GCP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[src/gcp_pkg.sv]
// ----------------------------------------------------------------------------
// gcp_pkg
// types, codes and helpers shared by the glyph column packer modules
// ----------------------------------------------------------------------------
package gcp_pkg;

    localparam int ROW_BYTES = 32;
    localparam int ROW_HALF  = ROW_BYTES / 2;
    localparam int ROW_IDX_W = $clog2(ROW_BYTES);

    // opcodes
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_COLUMN = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // register indexes
    localparam logic [1:0] REG_Y_DIRECTION  = 2'd0;
    localparam logic [1:0] REG_DOUBLE_SIZE  = 2'd1;
    localparam logic [1:0] REG_START_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_YDATA,
        ST_YCARRY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic begin_op;
        logic x_column;
        logic y_load;
        logic idx_clear;
        logic idx_inc;
        logic emit_flush;
        logic emit_ydata;
        logic emit_ycarry;
        logic clear_rows;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic y_dir;
        logic phase_nz;
        logic x_wrap;
        logic slot_free;
        logic flush_last;
        logic step_last;
        logic carry_due;
    } sts_t;

    // each nibble bit becomes two adjacent bits
    function automatic logic [7:0] widen(input logic [3:0] nib);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 4; i++) begin
            r[2*i]   = nib[i];
            r[2*i+1] = nib[i];
        end
        return r;
    endfunction

endpackage

[src/gcp_ctrl.sv]
// ----------------------------------------------------------------------------
// gcp_ctrl
// sequencer: takes items, steps the flush and realign sequences and
// issues emit commands only when the output register has room
// ----------------------------------------------------------------------------
`include "glyph_column_packer_assert.svh"

module gcp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    opcode,
    input  gcp_pkg::sts_t sts,
    output gcp_pkg::cmd_t cmd
);

    gcp_pkg::state_t state_reg, state_next;
    logic            flush_clear_reg, flush_clear_next;
    logic            accept;

    assign in_stall = (state_reg != gcp_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gcp_pkg::ST_IDLE;
            flush_clear_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            flush_clear_reg <= flush_clear_next;
        end
    end

    // next state
    always_comb
    begin
        state_next       = state_reg;
        flush_clear_next = flush_clear_reg;
        case (state_reg)
            gcp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        gcp_pkg::OP_COLUMN:
                        begin
                            flush_clear_next = 1'b1;
                            if (sts.y_dir)
                                state_next = gcp_pkg::ST_YDATA;
                            else if (sts.x_wrap)
                                state_next = gcp_pkg::ST_FLUSH;
                        end
                        gcp_pkg::OP_FINISH:
                        begin
                            flush_clear_next = 1'b0;
                            if (!sts.y_dir && sts.phase_nz)
                                state_next = gcp_pkg::ST_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            gcp_pkg::ST_FLUSH:
            begin
                if (sts.slot_free && sts.flush_last)
                    state_next = gcp_pkg::ST_IDLE;
            end
            gcp_pkg::ST_YDATA:
            begin
                if (sts.slot_free)
                begin
                    if (sts.carry_due)
                        state_next = gcp_pkg::ST_YCARRY;
                    else if (sts.step_last)
                        state_next = gcp_pkg::ST_IDLE;
                end
            end
            gcp_pkg::ST_YCARRY:
            begin
                if (sts.slot_free)
                    state_next = sts.step_last ? gcp_pkg::ST_IDLE : gcp_pkg::ST_YDATA;
            end
            default: state_next = gcp_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            gcp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.idx_clear = 1'b1;
                    case (opcode)
                        gcp_pkg::OP_BEGIN:  cmd.begin_op = 1'b1;
                        gcp_pkg::OP_COLUMN:
                        begin
                            cmd.y_load   = sts.y_dir;
                            cmd.x_column = !sts.y_dir;
                        end
                        default: ;
                    endcase
                end
            end
            gcp_pkg::ST_FLUSH:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_flush = 1'b1;
                    cmd.clear_rows = sts.flush_last && flush_clear_reg;
                    cmd.idx_inc    = !sts.flush_last;
                end
            end
            gcp_pkg::ST_YDATA:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_ydata = 1'b1;
                    cmd.idx_inc    = !sts.carry_due && !sts.step_last;
                end
            end
            gcp_pkg::ST_YCARRY:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_ycarry = 1'b1;
                    cmd.idx_inc     = !sts.step_last;
                end
            end
            default: cmd = '0;
        endcase
    end

    `GCP_ASSERT_IMP(a_emit_has_room,
        cmd.emit_flush || cmd.emit_ydata || cmd.emit_ycarry, sts.slot_free,
        "emit issued while output register is full")
    `GCP_ASSERT_IMP(a_busy_no_start,
        state_reg != gcp_pkg::ST_IDLE, !(cmd.begin_op || cmd.x_column || cmd.y_load),
        "item work started while busy")

endmodule

[src/gcp_datapath.sv]
// ----------------------------------------------------------------------------
// gcp_datapath
// configuration registers, row buffer, column phase, realigner carry,
// sequence counter and the output register
// ----------------------------------------------------------------------------
`include "glyph_column_packer_assert.svh"

module gcp_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          write_en,
    input  logic [1:0]    write_index,
    input  logic [2:0]    write_data,
    input  logic [7:0]    upper_byte,
    input  logic [7:0]    lower_byte,
    input  logic          out_stall,
    input  gcp_pkg::cmd_t cmd,
    output gcp_pkg::sts_t sts,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          last
);

    logic       y_dir_reg, dbl_reg;
    logic [2:0] offset_reg;

    logic [7:0] rows_reg [gcp_pkg::ROW_BYTES];
    logic [7:0] rows_next [gcp_pkg::ROW_BYTES];
    logic [2:0] phase_reg, phase_next;
    logic [7:0] carry_reg, carry_next;
    logic [1:0] ccount_reg, ccount_next;
    logic [gcp_pkg::ROW_IDX_W-1:0] idx_reg, idx_next;
    logic [7:0] up_reg, lo_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       last_reg, last_next;

    logic [gcp_pkg::ROW_BYTES-1:0] hit_nrm, hit_dbl;
    logic [7:0] mask_nrm, mask_dbl;
    logic [2:0] phase_step;
    logic [7:0] ybyte, yshift, ycarry_new;
    logic [2:0] lshift, ccount_inc, climit;
    logic       flush_last, step_last, carry_due;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_dir_reg  <= 1'b1;
            dbl_reg    <= 1'b0;
            offset_reg <= 3'd0;
        end
        else if (write_en)
        begin
            case (write_index)
                gcp_pkg::REG_Y_DIRECTION:  y_dir_reg  <= write_data[0];
                gcp_pkg::REG_DOUBLE_SIZE:  dbl_reg    <= write_data[0];
                gcp_pkg::REG_START_OFFSET: offset_reg <= write_data;
                default: ;
            endcase
        end
    end

    // which rows take a bit from the incoming column
    for (genvar r = 0; r < gcp_pkg::ROW_BYTES; r++)
    begin : g_hit
        localparam int DBIT = 7 - (r % gcp_pkg::ROW_HALF) / 2;
        localparam int NBIT = 7 - (r % 8);
        if (r < gcp_pkg::ROW_HALF)
        begin : g_lo
            assign hit_dbl[r] = lower_byte[DBIT];
        end
        else
        begin : g_up
            assign hit_dbl[r] = upper_byte[DBIT];
        end
        if (r < 8)
        begin : g_nlo
            assign hit_nrm[r] = lower_byte[NBIT];
        end
        else if (r < gcp_pkg::ROW_HALF)
        begin : g_nup
            assign hit_nrm[r] = upper_byte[NBIT];
        end
        else
        begin : g_none
            assign hit_nrm[r] = 1'b0;
        end
    end

    assign mask_nrm   = 8'h80 >> phase_reg;
    assign mask_dbl   = 8'hC0 >> {phase_reg[2:1], 1'b0};
    assign phase_step = dbl_reg ? phase_reg + 3'd2 : phase_reg + 3'd1;

    // realigner byte for the current step
    always_comb
    begin
        if (dbl_reg)
        begin
            case (idx_reg[1:0])
                2'd0:    ybyte = gcp_pkg::widen(up_reg[7:4]);
                2'd1:    ybyte = gcp_pkg::widen(up_reg[3:0]);
                2'd2:    ybyte = gcp_pkg::widen(lo_reg[7:4]);
                default: ybyte = gcp_pkg::widen(lo_reg[3:0]);
            endcase
        end
        else
        begin
            ybyte = idx_reg[0] ? lo_reg : up_reg;
        end
    end

    assign lshift     = 3'(4'd8 - {1'b0, offset_reg});
    assign yshift     = (offset_reg == 3'd0) ? ybyte : (carry_reg | (ybyte >> offset_reg));
    assign ycarry_new = ybyte << lshift;
    assign ccount_inc = {1'b0, ccount_reg} + 3'd1;
    assign climit     = dbl_reg ? 3'd4 : 3'd2;
    assign carry_due  = (offset_reg != 3'd0) && (ccount_inc == climit);

    assign flush_last = (idx_reg == {dbl_reg, {(gcp_pkg::ROW_IDX_W-1){1'b1}}});
    assign step_last  = dbl_reg ? (idx_reg == gcp_pkg::ROW_IDX_W'(7))
                                : (idx_reg == gcp_pkg::ROW_IDX_W'(1));

    always_comb
    begin
        rows_next   = rows_reg;
        phase_next  = phase_reg;
        carry_next  = carry_reg;
        ccount_next = ccount_reg;

        if (cmd.begin_op || cmd.clear_rows)
        begin
            for (int i = 0; i < gcp_pkg::ROW_BYTES; i++)
                rows_next[i] = 8'h00;
        end
        else if (cmd.x_column)
        begin
            for (int i = 0; i < gcp_pkg::ROW_BYTES; i++)
            begin
                if (dbl_reg ? hit_dbl[i] : hit_nrm[i])
                    rows_next[i] = rows_reg[i] | (dbl_reg ? mask_dbl : mask_nrm);
            end
        end

        if (cmd.begin_op)
        begin
            phase_next  = offset_reg & (dbl_reg ? 3'b110 : 3'b111);
            carry_next  = 8'h00;
            ccount_next = 2'd0;
        end
        else if (cmd.x_column)
        begin
            phase_next = phase_step;
        end
        else if (cmd.emit_ydata && (offset_reg != 3'd0))
        begin
            carry_next  = ycarry_new;
            ccount_next = carry_due ? 2'd0 : ccount_inc[1:0];
        end
        else if (cmd.emit_ycarry)
        begin
            carry_next = 8'h00;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;
    end

    // output register
    always_comb
    begin
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit_flush)
        begin
            out_byte_next  = rows_reg[idx_reg];
            last_next      = flush_last;
            out_valid_next = 1'b1;
        end
        else if (cmd.emit_ydata)
        begin
            out_byte_next  = yshift;
            last_next      = step_last && !carry_due;
            out_valid_next = 1'b1;
        end
        else if (cmd.emit_ycarry)
        begin
            out_byte_next  = carry_reg;
            last_next      = step_last;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gcp_pkg::ROW_BYTES; i++)
                rows_reg[i] <= 8'h00;
            phase_reg     <= 3'd0;
            carry_reg     <= 8'h00;
            ccount_reg    <= 2'd0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            phase_reg     <= phase_next;
            carry_reg     <= carry_next;
            ccount_reg    <= ccount_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.y_load)
        begin
            up_reg <= upper_byte;
            lo_reg <= lower_byte;
        end
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign sts.y_dir      = y_dir_reg;
    assign sts.phase_nz   = (phase_reg != 3'd0);
    assign sts.x_wrap     = (phase_step == 3'd0);
    assign sts.slot_free  = !out_valid_reg || !out_stall;
    assign sts.flush_last = flush_last;
    assign sts.step_last  = step_last;
    assign sts.carry_due  = carry_due;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    `GCP_ASSERT_NXT(a_begin_clears_carry, cmd.begin_op,
        carry_reg == 8'h00 && ccount_reg == 2'd0,
        "begin left realigner carry state")
    `GCP_ASSERT_NXT(a_carry_sent_cleared, cmd.emit_ycarry,
        carry_reg == 8'h00 && out_valid_reg,
        "carry byte not cleared after it was sent")

endmodule

[src/glyph_column_packer.sv]
// ----------------------------------------------------------------------------
// glyph_column_packer
// packs 16-pixel glyph columns (two bytes each) into display bytes, either
// transposed through a row buffer (X mode) or passed on through a bit-offset
// realigner (Y mode), at normal or doubled size
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   ---------------------------------
//   config    write_en                write_index, write_data
//   input     in_valid / in_stall     opcode, upper_byte, lower_byte
//   output    out_valid / out_stall   out_byte, last
//
// begin, finish without flush and an X column that does not wrap start no sequence;
// a wrapping X column or a flushing finish sends 16 row bytes (32 doubled) and a
// Y column sends its output bytes (2 to 3 normal, 8 to 10 doubled); no new item is
// taken until the sequence is through
// out_stall holds the output register and pauses the sequencer
// rst_n (async, active low) restores register defaults, clears rows, phase, carry
//
module glyph_column_packer (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       write_en,
    input  logic [1:0] write_index,
    input  logic [2:0] write_data,
    // input items
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] upper_byte,
    input  logic [7:0] lower_byte,
    // result items
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last
);

    gcp_pkg::cmd_t cmd;
    gcp_pkg::sts_t sts;

    // sequencer: item intake, flush and realign steps
    gcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    // row buffer, realigner and output register
    gcp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .upper_byte  (upper_byte),
        .lower_byte  (lower_byte),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last        (last)
    );

endmodule

[sim/glyph_column_packer_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_column_packer_check
// watches the config port and both item channels of the packer, predicts the
// display bytes of every accepted item and compares them with what comes out
// ----------------------------------------------------------------------------
module glyph_column_packer_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        write_en,
    input  logic [1:0]  write_index,
    input  logic [2:0]  write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  upper_byte,
    input  logic [7:0]  lower_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        last,
    output int unsigned error_count,
    output int unsigned pending_bytes,
    output int unsigned checked_bytes
);
    import gcp_pkg::*;

    localparam int MAX_REPORTS = 30;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } disp_byte_t;

    disp_byte_t expected_bytes[$];

    // shadow registers
    logic       cfg_y;
    logic       cfg_double;
    logic [2:0] cfg_offset;

    // shadow block state
    logic [7:0] row_image [ROW_BYTES];
    logic [2:0] phase;
    logic [7:0] carry_bits;
    logic [1:0] carry_cnt;

    function automatic logic [7:0] spread_nibble(input logic [3:0] n);
        return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        disp_byte_t e;
        e.data = b;
        e.last = 1'b0;
        expected_bytes.push_back(e);
    endtask

    task automatic clear_rows();
        for (int i = 0; i < ROW_BYTES; i++)
            row_image[i] = 8'h00;
    endtask

    task automatic dump_rows();
        int count;
        count = cfg_double ? ROW_BYTES : ROW_BYTES / 2;
        for (int i = 0; i < count; i++)
            queue_byte(row_image[i]);
    endtask

    // shift a byte by the start offset, keeping leftover bits as carry
    task automatic shift_in_byte(input logic [7:0] b);
        logic [2:0] lim;
        logic [2:0] nxt;
        lim = cfg_double ? 3'd4 : 3'd2;
        if (cfg_offset == 3'd0)
            queue_byte(b);
        else
        begin
            queue_byte(carry_bits | (b >> cfg_offset));
            carry_bits = b << (8 - cfg_offset);
            nxt = {1'b0, carry_cnt} + 3'd1;
            carry_cnt = nxt[1:0];
            if (nxt == lim)
            begin
                queue_byte(carry_bits);
                carry_bits = 8'h00;
                carry_cnt = 2'd0;
            end
        end
    endtask

    task automatic stack_column(input logic [7:0] up, input logic [7:0] lo);
        if (!cfg_double)
        begin
            shift_in_byte(up);
            shift_in_byte(lo);
        end
        else
        begin
            repeat (2)
            begin
                shift_in_byte(spread_nibble(up[7:4]));
                shift_in_byte(spread_nibble(up[3:0]));
                shift_in_byte(spread_nibble(lo[7:4]));
                shift_in_byte(spread_nibble(lo[3:0]));
            end
        end
    endtask

    task automatic transpose_column(input logic [7:0] up, input logic [7:0] lo);
        int         pos;
        logic [7:0] mask;
        if (!cfg_double)
        begin
            pos = 7 - int'(phase);
            for (int c = 0; c < 8; c++)
            begin
                if (lo[7 - c])
                    row_image[c][pos] = 1'b1;
                if (up[7 - c])
                    row_image[8 + c][pos] = 1'b1;
            end
            phase = phase + 3'd1;
        end
        else
        begin
            // odd phase places bits as if its low bit were clear
            pos = 6 - int'({phase[2:1], 1'b0});
            mask = 8'h03 << pos;
            for (int c = 0; c < 8; c++)
            begin
                if (lo[7 - c])
                begin
                    row_image[2 * c]     = row_image[2 * c] | mask;
                    row_image[2 * c + 1] = row_image[2 * c + 1] | mask;
                end
                if (up[7 - c])
                begin
                    row_image[2 * c + 16] = row_image[2 * c + 16] | mask;
                    row_image[2 * c + 17] = row_image[2 * c + 17] | mask;
                end
            end
            phase = phase + 3'd2;
        end
        if (phase == 3'd0)
        begin
            dump_rows();
            clear_rows();
        end
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [7:0] up,
                                input logic [7:0] lo);
        int before_size;
        before_size = expected_bytes.size();
        case (op)
            OP_BEGIN:
            begin
                clear_rows();
                carry_bits = 8'h00;
                carry_cnt = 2'd0;
                phase = cfg_double ? {cfg_offset[2:1], 1'b0} : cfg_offset;
            end
            OP_COLUMN:
            begin
                if (cfg_y)
                    stack_column(up, lo);
                else
                    transpose_column(up, lo);
            end
            OP_FINISH:
            begin
                if (!cfg_y && phase != 3'd0)
                    dump_rows();
            end
            default: ;
        endcase
        if (expected_bytes.size() > before_size)
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endtask

    task automatic note_error();
        error_count = error_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        disp_byte_t e;
        if (!rst_n)
        begin
            cfg_y = 1'b1;
            cfg_double = 1'b0;
            cfg_offset = 3'd0;
            clear_rows();
            phase = 3'd0;
            carry_bits = 8'h00;
            carry_cnt = 2'd0;
            expected_bytes.delete();
            error_count = 0;
            checked_bytes = 0;
            pending_bytes = 0;
        end
        else
        begin
            if (write_en)
            begin
                case (write_index)
                    REG_Y_DIRECTION:  cfg_y = write_data[0];
                    REG_DOUBLE_SIZE:  cfg_double = write_data[0];
                    REG_START_OFFSET: cfg_offset = write_data;
                    default: ;
                endcase
            end

            // results come from older items, so compare before predicting
            if (out_valid && !out_stall)
            begin
                checked_bytes = checked_bytes + 1;
                if (expected_bytes.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: unexpected result byte %02h last %b",
                                 $time, out_byte, last);
                    note_error();
                end
                else
                begin
                    e = expected_bytes.pop_front();
                    if (out_byte !== e.data)
                    begin
                        if (error_count < MAX_REPORTS)
                            $display("%0t: out_byte expected %02h actual %02h",
                                     $time, e.data, out_byte);
                        note_error();
                    end
                    if (last !== e.last)
                    begin
                        if (error_count < MAX_REPORTS)
                            $display("%0t: last expected %b actual %b",
                                     $time, e.last, last);
                        note_error();
                    end
                end
            end

            if (in_valid && !in_stall)
                predict_item(opcode, upper_byte, lower_byte);

            pending_bytes = expected_bytes.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the glyph column packer with directed and random item sequences in
// both modes and sizes, under several idle and stall patterns; a checker
// beside the block predicts and compares every display byte
// ----------------------------------------------------------------------------
module testbench;
    import gcp_pkg::*;

    // opcode and register index with no function in the block
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] REG_NONE  = 2'd3;

    localparam int RANDOM_ITEMS   = 320;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 3000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       write_en = 1'b0;
    logic [1:0] write_index = 2'd0;
    logic [2:0] write_data = 3'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] opcode = 2'd0;
    logic [7:0] upper_byte = 8'h00;
    logic [7:0] lower_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last;

    int unsigned error_count;
    int unsigned pending_bytes;
    int unsigned checked_bytes;

    // idle percentages of the current phase
    int          send_idle = 0;
    int          stall_pct = 0;
    int unsigned items_accepted = 0;
    int unsigned quiet_cycles = 0;

    always #2 clk = ~clk;

    glyph_column_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .upper_byte  (upper_byte),
        .lower_byte  (lower_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last)
    );

    glyph_column_packer_check checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .write_en      (write_en),
        .write_index   (write_index),
        .write_data    (write_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .upper_byte    (upper_byte),
        .lower_byte    (lower_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last          (last),
        .error_count   (error_count),
        .pending_bytes (pending_bytes),
        .checked_bytes (checked_bytes)
    );

    // receiver stall, redrawn every cycle from the current phase
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles where nothing moves, plus item count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || write_en)
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: watchdog, no handshake for %0d cycles",
                             $time, quiet_cycles);
                    $display("testbench: errors");
                    $finish;
                end
            end
            if (in_valid && !in_stall)
                items_accepted <= items_accepted + 1;
        end
    end

    // glyph byte with a bias toward all-clear and all-set
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return 8'h00;
        else if (roll < 30)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // offer one item, idling first as the phase says; returns at the
    // falling edge after it was taken
    task automatic send(input logic [1:0] op, input logic [7:0] up, input logic [7:0] lo);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        upper_byte <= up;
        lower_byte <= lo;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending, wait for every expected byte, then let the block go quiet
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_bytes != 0)
            @(negedge clk);
        repeat (extra)
            @(negedge clk);
    endtask

    // one write per register; spare data bits get random values
    task automatic write_config(input logic y, input logic dbl, input logic [2:0] off);
        logic [1:0] pad_y;
        logic [1:0] pad_d;
        pad_y = 2'($urandom_range(3));
        pad_d = 2'($urandom_range(3));
        write_en <= 1'b1;
        write_index <= REG_Y_DIRECTION;
        write_data <= {pad_y, y};
        @(negedge clk);
        write_index <= REG_DOUBLE_SIZE;
        write_data <= {pad_d, dbl};
        @(negedge clk);
        write_index <= REG_START_OFFSET;
        write_data <= off;
        @(negedge clk);
        write_en <= 1'b0;
    endtask

    initial
    begin
        int         sent;
        int         seg;
        int         len;
        int         roll;
        logic       pick_y;
        logic       pick_d;
        logic [2:0] pick_off;
        int         idle_send [4];
        int         idle_recv [4];

        // no idling, sender idle, receiver stalling, both
        idle_send = '{0, 72, 0, 32};
        idle_recv = '{0, 0, 72, 32};

        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----

        // reset settings: Y mode, normal size, no offset, bytes pass through
        send(OP_COLUMN, 8'h00, 8'hFF);
        send(OP_COLUMN, 8'hFF, 8'h00);
        // Y-mode finish gives nothing, unused opcode is ignored
        send(OP_FINISH, 8'h00, 8'h00);
        send(OP_UNUSED, 8'hFF, 8'hFF);
        settle(DRAIN_CYCLES);

        // write to an index with no register behind it
        write_en <= 1'b1;
        write_index <= REG_NONE;
        write_data <= 3'($urandom_range(7));
        @(negedge clk);

        // X mode, normal size: eight columns fill the buffer and flush it
        write_config(1'b0, 1'b0, 3'd0);
        send(OP_BEGIN, 8'h00, 8'h00);
        for (int i = 0; i < 8; i++)
            send(OP_COLUMN, 8'h80 >> i, 8'h01 << i);
        settle(DRAIN_CYCLES);

        // X doubled, odd offset rounds down; finish flushes a partial buffer,
        // a second finish sends the same buffer again
        write_config(1'b0, 1'b1, 3'd5);
        send(OP_BEGIN, 8'h00, 8'h00);
        send(OP_COLUMN, 8'hFF, 8'hFF);
        send(OP_FINISH, 8'h00, 8'h00);
        send(OP_FINISH, 8'h00, 8'h00);
        settle(DRAIN_CYCLES);

        // Y mode with the largest shift at normal size, then doubled with a shift of 3
        write_config(1'b1, 1'b0, 3'd7);
        send(OP_BEGIN, 8'h00, 8'h00);
        send(OP_COLUMN, 8'hFF, 8'hFF);
        send(OP_COLUMN, 8'h01, 8'h80);
        settle(DRAIN_CYCLES);
        write_config(1'b1, 1'b1, 3'd3);
        send(OP_BEGIN, 8'h00, 8'h00);
        send(OP_COLUMN, 8'hA5, 8'h5A);
        settle(DRAIN_CYCLES);

        // odd phase left over from normal size, then doubled without a begin
        write_config(1'b0, 1'b0, 3'd3);
        send(OP_BEGIN, 8'h00, 8'h00);
        settle(DRAIN_CYCLES);
        write_config(1'b0, 1'b1, 3'd3);
        send(OP_COLUMN, 8'hFF, 8'h00);
        send(OP_FINISH, 8'h00, 8'h00);

        // ---- random part ----
        sent = 0;
        seg = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle(DRAIN_CYCLES);
            send_idle = idle_send[seg % 4];
            stall_pct <= idle_recv[seg % 4];

            // first segments walk the mode corners at both offset extremes;
            // later ones are random and sometimes keep the old settings
            if (seg < 8 || $urandom_range(3) != 0)
            begin
                if (seg < 8)
                begin
                    pick_y = seg[1];
                    pick_d = seg[2];
                    pick_off = seg[0] ? 3'd7 : 3'd0;
                end
                else
                begin
                    pick_y = 1'($urandom_range(1));
                    pick_d = 1'($urandom_range(1));
                    pick_off = 3'($urandom_range(7));
                end
                write_config(pick_y, pick_d, pick_off);
            end

            // mostly well-formed: begin, columns, finish
            if ($urandom_range(9) != 0)
            begin
                send(OP_BEGIN, pick_byte(), pick_byte());
                sent++;
            end
            len = $urandom_range(20, 1);
            for (int k = 0; k < len; k++)
            begin
                // sender holds off until the block has delivered everything
                if (seg % 5 == 2 && k == len / 2)
                    settle(0);
                roll = $urandom_range(99);
                if (roll < 5)
                    send(OP_UNUSED, pick_byte(), pick_byte());
                else if (roll < 10)
                begin
                    send(OP_FINISH, pick_byte(), pick_byte());
                    sent++;
                end
                else if (roll < 13)
                begin
                    send(OP_BEGIN, pick_byte(), pick_byte());
                    sent++;
                end
                else
                begin
                    send(OP_COLUMN, pick_byte(), pick_byte());
                    sent++;
                end
            end
            if ($urandom_range(1) != 0)
            begin
                send(OP_FINISH, pick_byte(), pick_byte());
                sent++;
            end
            seg++;
        end

        // drain and give the block time to show any stray byte
        settle(DRAIN_CYCLES);

        $display("covered %0d items in %0d random segments over four idle patterns",
                 items_accepted, seg);
        $display("checked %0d display bytes in X and Y mode, normal and doubled",
                 checked_bytes);
        if (error_count == 0 && pending_bytes == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
